### hw/rtl/apd_pkg.sv
// Package for the allpass reverb diffuser: shared widths, constants, control types
// and the microcode program of the sequencer.
// Depends on nothing; the sequencer, datapath and top files of the block import it.
package apd_pkg;

   localparam int STAGES_DEF      = 4;
   localparam int MAX_DELAY_DEF   = 4096;
   localparam int PACKED_SECTIONS = 4;

   localparam int SAMPLE_W        = 16;
   localparam int DELAY_FIELD_W   = 12;
   localparam int GAIN_W          = 16;
   localparam int GAIN_LIMIT      = 32440;

   localparam int COUNT_REG_W     = 3;
   localparam int DELAYS_REG_W    = PACKED_SECTIONS * DELAY_FIELD_W;
   localparam int GAINS_REG_W     = PACKED_SECTIONS * GAIN_W;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = GAINS_REG_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_STAGE_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STAGE_DELAYS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STAGE_GAINS  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_WAIT,
      ST_ADDR,
      ST_FETCH,
      ST_MUL,
      ST_SUM,
      ST_OUT
   } apd_step_type;

   typedef enum logic [2:0] {
      JC_ALWAYS,
      JC_CLR_LAST,
      JC_REQ,
      JC_STAGES_DONE,
      JC_OUT_FREE
   } apd_cond_type;

   // Strobes that one control word drives into the datapath.
   typedef struct packed {
      logic in_ready;
      logic take_in;
      logic rd_en;
      logic ld_diff;
      logic ld_prod;
      logic ld_sum;
      logic ld_out;
      logic clr_wr;
   } apd_ctl_type;

   // Conditions that the datapath reports back to the sequencer.
   typedef struct packed {
      logic clr_last;
      logic stages_done;
   } apd_flags_type;

   typedef struct packed {
      apd_ctl_type  ctl;
      apd_cond_type cond;
      apd_step_type next_t;
      apd_step_type next_f;
   } apd_uword_type;

   // The program: each step names its strobes, the condition it tests and the
   // step taken when the condition holds or fails.
   function automatic apd_uword_type apd_ucode(input apd_step_type step);
      apd_uword_type w;
      w = '0;
      w.cond   = JC_ALWAYS;
      w.next_t = ST_WAIT;
      w.next_f = ST_WAIT;
      case (step)
         ST_CLEAR: begin
            w.ctl.clr_wr = 1'b1;
            w.cond       = JC_CLR_LAST;
            w.next_t     = ST_WAIT;
            w.next_f     = ST_CLEAR;
         end
         ST_WAIT: begin
            w.ctl.in_ready = 1'b1;
            w.cond         = JC_REQ;
            w.next_t       = ST_ADDR;
            w.next_f       = ST_WAIT;
         end
         ST_ADDR: begin
            w.ctl.rd_en = 1'b1;
            w.cond      = JC_STAGES_DONE;
            w.next_t    = ST_OUT;
            w.next_f    = ST_FETCH;
         end
         ST_FETCH: begin
            w.ctl.ld_diff = 1'b1;
            w.next_t      = ST_MUL;
            w.next_f      = ST_MUL;
         end
         ST_MUL: begin
            w.ctl.ld_prod = 1'b1;
            w.next_t      = ST_SUM;
            w.next_f      = ST_SUM;
         end
         ST_SUM: begin
            w.ctl.ld_sum = 1'b1;
            w.next_t     = ST_ADDR;
            w.next_f     = ST_ADDR;
         end
         ST_OUT: begin
            w.ctl.ld_out = 1'b1;
            w.cond       = JC_OUT_FREE;
            w.next_t     = ST_WAIT;
            w.next_f     = ST_OUT;
         end
         default: begin
            w.next_t = ST_WAIT;
            w.next_f = ST_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

### hw/rtl/apd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the section history store.
module apd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/apd_sequencer.sv
// Microcoded sequencer: step counter, control word lookup and branch logic.
// Depends on apd_pkg for the step, condition and control word types.
module apd_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  out_free,
   input  apd_pkg::apd_flags_type flags,
   output apd_pkg::apd_ctl_type   ctl
);
   import apd_pkg::*;

   apd_step_type  step_ff;
   apd_step_type  step_in;
   apd_uword_type uword;
   logic          cond_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      uword = apd_ucode(step_ff);
      case (uword.cond)
         JC_ALWAYS:      cond_hit = 1'b1;
         JC_CLR_LAST:    cond_hit = flags.clr_last;
         JC_REQ:         cond_hit = req_valid;
         JC_STAGES_DONE: cond_hit = flags.stages_done;
         JC_OUT_FREE:    cond_hit = out_free;
         default:        cond_hit = 1'b1;
      endcase
      step_in = cond_hit ? uword.next_t : uword.next_f;

      ctl         = uword.ctl;
      ctl.take_in = uword.ctl.in_ready & req_valid;
      ctl.ld_out  = uword.ctl.ld_out & out_free;
   end

endmodule

### hw/rtl/apd_datapath.sv
// Datapath of the diffuser: address generation, history RAM, one shared multiplier,
// rounding and saturation, and the clearing pass counter.
// Depends on apd_pkg and instantiates apd_ram.
module apd_datapath #(
   parameter int STAGES    = apd_pkg::STAGES_DEF,
   parameter int MAX_DELAY = apd_pkg::MAX_DELAY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  apd_pkg::apd_ctl_type                 ctl,
   input  logic signed [apd_pkg::SAMPLE_W-1:0]  sample_in,
   input  logic [apd_pkg::COUNT_REG_W-1:0]      stage_count,
   input  logic [apd_pkg::DELAYS_REG_W-1:0]     stage_delays,
   input  logic [apd_pkg::GAINS_REG_W-1:0]      stage_gains,
   output logic signed [apd_pkg::SAMPLE_W-1:0]  sample_out,
   output apd_pkg::apd_flags_type               flags
);
   import apd_pkg::*;

   localparam int SECTIONS = (STAGES < PACKED_SECTIONS) ? STAGES : PACKED_SECTIONS;
   localparam int CNT_W    = $clog2(SECTIONS + 1);
   localparam int IDX_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int PW       = $clog2(MAX_DELAY);
   localparam int DEPTH    = SECTIONS * MAX_DELAY;
   localparam int AW       = $clog2(DEPTH);
   localparam int DW       = (PW > DELAY_FIELD_W) ? PW : DELAY_FIELD_W;
   localparam int RAM_W    = 2 * SAMPLE_W;

   localparam logic [PW:0] MAX_DELAY_X = (PW + 1)'(MAX_DELAY);

   logic [CNT_W-1:0]            stage_ff, stage_in;
   logic [PW-1:0]               wp_ff, wp_in;
   logic [AW-1:0]               clr_ff, clr_in;
   logic signed [SAMPLE_W-1:0]  x_ff, x_in;
   logic signed [SAMPLE_W-1:0]  xd_ff, xd_in;
   logic signed [SAMPLE_W:0]    diff_ff, diff_in;
   logic signed [GAIN_W-1:0]    g_ff, g_in;
   logic signed [32:0]          prod_ff, prod_in;

   logic [CNT_W-1:0]            count_eff;
   logic [IDX_W-1:0]            idx;
   logic [DELAY_FIELD_W-1:0]    m_raw;
   logic [PW-1:0]               m_cl;
   logic [PW-1:0]               rd_slot;
   logic [AW-1:0]               base;
   logic signed [GAIN_W-1:0]    g_raw;
   logic signed [33:0]          acc;
   logic signed [18:0]          y_wide;
   logic signed [SAMPLE_W-1:0]  y_sat;

   logic                        ram_we, ram_re;
   logic [AW-1:0]               ram_waddr, ram_raddr;
   logic [RAM_W-1:0]            ram_wdata, ram_rdata;

   apd_ram #(
      .WIDTH (RAM_W),
      .DEPTH (DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         wp_ff    <= '0;
         clr_ff   <= '0;
      end else begin
         stage_ff <= stage_in;
         wp_ff    <= wp_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      xd_ff   <= xd_in;
      diff_ff <= diff_in;
      g_ff    <= g_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      // Active sections, limited by the build and by the packed fields.
      if (int'(stage_count) > SECTIONS) begin
         count_eff = CNT_W'(SECTIONS);
      end else begin
         count_eff = CNT_W'(stage_count);
      end
      idx  = stage_ff[IDX_W-1:0];
      base = AW'(32'(idx) * MAX_DELAY);

      m_raw = stage_delays[idx * DELAY_FIELD_W +: DELAY_FIELD_W];
      if (m_raw == '0) begin
         m_cl = PW'(1);
      end else if (DW'(m_raw) > DW'(MAX_DELAY - 1)) begin
         m_cl = PW'(MAX_DELAY - 1);
      end else begin
         m_cl = PW'(m_raw);
      end
      if (wp_ff >= m_cl) begin
         rd_slot = wp_ff - m_cl;
      end else begin
         rd_slot = PW'({1'b0, wp_ff} + MAX_DELAY_X - {1'b0, m_cl});
      end

      g_raw = signed'(stage_gains[idx * GAIN_W +: GAIN_W]);
      if (g_raw > GAIN_W'(GAIN_LIMIT)) begin
         g_in = GAIN_W'(GAIN_LIMIT);
      end else if (g_raw < -GAIN_W'(GAIN_LIMIT)) begin
         g_in = -GAIN_W'(GAIN_LIMIT);
      end else begin
         g_in = g_raw;
      end
      if (!ctl.ld_diff) begin
         g_in = g_ff;
      end

      // The section output is (g*(y_delayed - x) + x_delayed*2^15) / 2^15, rounded half up.
      acc    = 34'(prod_ff) + 34'(signed'({xd_ff, 15'd0})) + 34'sd16384;
      y_wide = acc[33:15];
      if (y_wide > 19'sd32767) begin
         y_sat = 16'sh7fff;
      end else if (y_wide < -19'sd32768) begin
         y_sat = 16'sh8000;
      end else begin
         y_sat = y_wide[SAMPLE_W-1:0];
      end

      x_in    = x_ff;
      xd_in   = xd_ff;
      diff_in = diff_ff;
      prod_in = prod_ff;
      stage_in = stage_ff;
      wp_in    = wp_ff;
      clr_in   = clr_ff;

      if (ctl.take_in) begin
         x_in     = sample_in;
         stage_in = '0;
      end
      if (ctl.ld_diff) begin
         xd_in   = signed'(ram_rdata[RAM_W-1:SAMPLE_W]);
         diff_in = (SAMPLE_W + 1)'(signed'(ram_rdata[SAMPLE_W-1:0])) - (SAMPLE_W + 1)'(x_ff);
      end
      if (ctl.ld_prod) begin
         prod_in = 33'(g_ff) * 33'(diff_ff);
      end
      if (ctl.ld_sum) begin
         x_in     = y_sat;
         stage_in = stage_ff + CNT_W'(1);
      end
      if (ctl.ld_out) begin
         if (wp_ff == PW'(MAX_DELAY - 1)) begin
            wp_in = '0;
         end else begin
            wp_in = wp_ff + PW'(1);
         end
      end
      if (ctl.clr_wr) begin
         clr_in = clr_ff + AW'(1);
      end

      ram_re    = ctl.rd_en && (stage_ff != count_eff);
      ram_raddr = base + AW'(rd_slot);
      ram_we    = ctl.ld_sum || ctl.clr_wr;
      if (ctl.clr_wr) begin
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else begin
         ram_waddr = base + AW'(wp_ff);
         ram_wdata = {x_ff, y_sat};
      end
   end

   assign sample_out        = x_ff;
   assign flags.clr_last    = (clr_ff == AW'(DEPTH - 1));
   assign flags.stages_done = (stage_ff == count_eff);

endmodule

### hw/rtl/allpass_cascade_reverb_diffuser_core.sv
// Top level of the allpass cascade reverb diffuser: configuration registers,
// result register and the sequencer and datapath instances.
// Depends on apd_pkg, apd_sequencer, apd_datapath and apd_ram.

// Each beat on the req_ channel carries one signed Q1.15 sample, which passes in
// series through the first stage_count Schroeder allpass sections (at most four, and
// at most STAGES); each section forms y = -g*x + x[n-M] + g*y[n-M] with its own
// delay M in samples (zero acts as one, long delays stop at MAX_DELAY-1) and its own
// Q1.15 gain clamped to +-0.99, then rounds half up and saturates to 16 bits. One
// rsp_ beat comes back for every sample taken. A short microcode program runs each
// section in four steps through one shared history RAM port and one shared 16x17
// multiplier, and a new sample is taken only once the last one has been loaded into
// the result register. After reset the block first clears its histories, one RAM
// word per cycle, min(STAGES,4)*MAX_DELAY words in all; req_stall stays high until
// that is done, whereas configuration writes are taken at any time.
// Registers should only be written while no sample is in flight.
module allpass_cascade_reverb_diffuser_core #(
   parameter int STAGES    = apd_pkg::STAGES_DEF,
   parameter int MAX_DELAY = apd_pkg::MAX_DELAY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [apd_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [apd_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   input  logic                                 csr_wr_en,
   input  logic [apd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [apd_pkg::CSR_DATA_W-1:0]       csr_wr_data
);
   import apd_pkg::*;

   logic [COUNT_REG_W-1:0]      stage_count_ff, stage_count_in;
   logic [DELAYS_REG_W-1:0]     stage_delays_ff, stage_delays_in;
   logic [GAINS_REG_W-1:0]      stage_gains_ff, stage_gains_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  rsp_data_ff, rsp_data_in;

   apd_ctl_type                 ctl;
   apd_flags_type               flags;
   logic                        out_free;
   logic signed [SAMPLE_W-1:0]  dp_sample;

   // The result register may be refilled when it is empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   apd_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .flags     (flags),
      .ctl       (ctl)
   );

   apd_datapath #(
      .STAGES    (STAGES),
      .MAX_DELAY (MAX_DELAY)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .sample_in    (req_sample_in),
      .stage_count  (stage_count_ff),
      .stage_delays (stage_delays_ff),
      .stage_gains  (stage_gains_ff),
      .sample_out   (dp_sample),
      .flags        (flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_count_ff  <= '0;
         stage_delays_ff <= '0;
         stage_gains_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         stage_count_ff  <= stage_count_in;
         stage_delays_ff <= stage_delays_in;
         stage_gains_ff  <= stage_gains_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      stage_count_in  = stage_count_ff;
      stage_delays_in = stage_delays_ff;
      stage_gains_in  = stage_gains_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_STAGE_COUNT:  stage_count_in  = csr_wr_data[COUNT_REG_W-1:0];
            CSR_STAGE_DELAYS: stage_delays_in = csr_wr_data[DELAYS_REG_W-1:0];
            CSR_STAGE_GAINS:  stage_gains_in  = csr_wr_data[GAINS_REG_W-1:0];
            default: begin
               // Writes to unused indices are dropped.
            end
         endcase
      end

      // The final program step loads the result register and retires the sample.
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (ctl.ld_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = dp_sample;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_stall      = !ctl.in_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

`ifndef SYNTH
   // No sample may be taken while the histories are still being cleared.
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      ctl.clr_wr |-> req_stall)
      else $error("sample accepted during history clearing");

   // A sample occupies the sequencer for several steps, so the next cycle stalls.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second sample accepted while one is in flight");

   // Loading the result register always presents a beat on the next cycle.
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      ctl.ld_out |=> rsp_valid)
      else $error("result load did not produce a response beat");
`endif

endmodule

### tb/sv/apd_check_pkg.sv
// Scoreboard for the allpass cascade diffuser: a bit-exact model of the section
// cascade and the queue of samples it predicts.
// Depends on apd_pkg for widths, register indexes and the gain limit.
`timescale 1ns / 100ps

package apd_check_pkg;
   import apd_pkg::*;

   localparam int HIST_DEPTH   = MAX_DELAY_DEF;
   localparam int ACTIVE_LIMIT = (STAGES_DEF < PACKED_SECTIONS) ? STAGES_DEF : PACKED_SECTIONS;

   class diffuser_scoreboard;
      logic [COUNT_REG_W-1:0]     stage_count;
      logic [DELAYS_REG_W-1:0]    stage_delays;
      logic [GAINS_REG_W-1:0]     stage_gains;
      logic signed [SAMPLE_W-1:0] in_hist  [STAGES_DEF*HIST_DEPTH];
      logic signed [SAMPLE_W-1:0] out_hist [STAGES_DEF*HIST_DEPTH];
      int unsigned                wr_pos;
      logic signed [SAMPLE_W-1:0] expected_samples [$];
      int                         error_count;

      function new();
         stage_count  = '0;
         stage_delays = '0;
         stage_gains  = '0;
         wr_pos       = 0;
         error_count  = 0;
         foreach (in_hist[i]) begin
            in_hist[i]  = '0;
            out_hist[i] = '0;
         end
      endfunction

      // Writes to the spare index are dropped, as the block does.
      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_STAGE_COUNT:  stage_count  = data[COUNT_REG_W-1:0];
            CSR_STAGE_DELAYS: stage_delays = data[DELAYS_REG_W-1:0];
            CSR_STAGE_GAINS:  stage_gains  = data[GAINS_REG_W-1:0];
            default: ;
         endcase
      endfunction

      // Runs one sample through the active sections and updates their histories.
      function logic signed [SAMPLE_W-1:0] run_cascade(logic signed [SAMPLE_W-1:0] sample);
         int unsigned active;
         int unsigned delay;
         int unsigned rd;
         int unsigned base;
         longint      x;
         longint      g;
         longint      acc;
         longint      y;
         active = stage_count;
         if (active > ACTIVE_LIMIT)
            active = ACTIVE_LIMIT;
         x = sample;
         for (int s = 0; s < active; s++) begin
            delay = stage_delays[DELAY_FIELD_W*s +: DELAY_FIELD_W];
            if (delay == 0)
               delay = 1;
            if (delay > HIST_DEPTH - 1)
               delay = HIST_DEPTH - 1;
            g = $signed(stage_gains[GAIN_W*s +: GAIN_W]);
            if (g > GAIN_LIMIT)
               g = GAIN_LIMIT;
            if (g < -GAIN_LIMIT)
               g = -GAIN_LIMIT;
            base = s * HIST_DEPTH;
            rd   = (wr_pos + HIST_DEPTH - delay) % HIST_DEPTH;
            acc  = -g * x + longint'(in_hist[base + rd]) * 32768
                 + g * longint'(out_hist[base + rd]);
            y = (acc + 16384) >>> 15;
            if (y > 32767)
               y = 32767;
            if (y < -32768)
               y = -32768;
            in_hist[base + wr_pos]  = x[SAMPLE_W-1:0];
            out_hist[base + wr_pos] = y[SAMPLE_W-1:0];
            x = y;
         end
         wr_pos = (wr_pos + 1) % HIST_DEPTH;
         return x[SAMPLE_W-1:0];
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] sample);
         expected_samples = {expected_samples, run_cascade(sample)};
      endfunction

      function void check_result(logic signed [SAMPLE_W-1:0] actual);
         logic signed [SAMPLE_W-1:0] expected;
         if (expected_samples.size() == 0) begin
            $error("sample_out beat with nothing expected: actual %0d", actual);
            error_count++;
            return;
         end
         expected = expected_samples.pop_front();
         if (actual !== expected) begin
            $error("sample_out mismatch: expected %0d, actual %0d", expected, actual);
            error_count++;
         end
      endfunction

      function int outstanding();
         return expected_samples.size();
      endfunction
   endclass

endpackage

### tb/sv/tb_top.sv
// Top of the diffuser testbench: clock, reset, register writes, sample and
// result beats under varying idle patterns, and the final verdict.
// Depends on apd_pkg, apd_check_pkg and allpass_cascade_reverb_diffuser_core.
`timescale 1ns / 100ps

module tb_top;
   import apd_pkg::*;
   import apd_check_pkg::*;

   localparam int CLK_PERIOD       = 10;
   localparam int RESET_CYCLES     = 6;
   localparam int RANDOM_PHASES    = 12;
   localparam int PHASE_BEATS      = 90;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES      = 60;
   // The timeout leaves a wide margin over a correct run, clearing pass included.
   localparam int TIMEOUT_NS       = 5_000_000;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_in  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       csr_wr_en      = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index      = '0;
   logic [CSR_DATA_W-1:0]      csr_wr_data    = '0;

   // Idle percentages; the receiver one is only changed by nonblocking
   // assignment so that the stall process picks it up free of races.
   int                         send_idle_pct  = 0;
   int                         recv_stall_pct = 0;

   // A long receiver hold-off is requested by bumping hold_requests; the stall
   // process counts it out itself and notes it as served.
   int                         hold_requests  = 0;
   int                         holds_served   = 0;
   int                         hold_left      = 0;

   diffuser_scoreboard         diffuser;

   allpass_cascade_reverb_diffuser_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Receiver side. A pending long hold-off takes precedence over the random
   // stall pattern; while it runs the block fills up and must stall its input.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         holds_served <= holds_served + 1;
         hold_left    <= LONG_HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Every result beat is checked against the oldest prediction. The values
   // read here are those from before the edge, so the sampling is race free.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         diffuser.check_result(rsp_sample_out);
   end

   initial begin
      #TIMEOUT_NS;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [CSR_DATA_W-1:0] wide_random();
      return {$urandom, $urandom};
   endfunction

   // Samples are mostly uniform, with the full-scale values and the values
   // around zero mixed in so that saturation is reached often.
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(15))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return '0;
         3: return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Short delays dominate so that the histories feed back within a phase; zero
   // and the longest delay turn up regularly too. Bits above the register are
   // random to show that they are dropped.
   function automatic logic [CSR_DATA_W-1:0] pick_delays();
      logic [CSR_DATA_W-1:0] data;
      data = wide_random();
      for (int s = 0; s < PACKED_SECTIONS; s++) begin
         case ($urandom_range(4))
            0: data[DELAY_FIELD_W*s +: DELAY_FIELD_W] = '0;
            1: data[DELAY_FIELD_W*s +: DELAY_FIELD_W] = DELAY_FIELD_W'($urandom_range(1, 4));
            2: data[DELAY_FIELD_W*s +: DELAY_FIELD_W] = DELAY_FIELD_W'($urandom_range(5, 64));
            3: data[DELAY_FIELD_W*s +: DELAY_FIELD_W] = '1;
            default: data[DELAY_FIELD_W*s +: DELAY_FIELD_W] = DELAY_FIELD_W'($urandom);
         endcase
      end
      return data;
   endfunction

   // Gains at full scale, at the upper clamp limit and just below the lower one, plus fully random ones.
   function automatic logic [CSR_DATA_W-1:0] pick_gains();
      logic [CSR_DATA_W-1:0] data;
      data = wide_random();
      for (int s = 0; s < PACKED_SECTIONS; s++) begin
         case ($urandom_range(5))
            0: data[GAIN_W*s +: GAIN_W] = 16'h7FFF;
            1: data[GAIN_W*s +: GAIN_W] = 16'h8000;
            2: data[GAIN_W*s +: GAIN_W] = GAIN_W'(GAIN_LIMIT);
            3: data[GAIN_W*s +: GAIN_W] = GAIN_W'(-GAIN_LIMIT - 1);
            default: ;
         endcase
      end
      return data;
   endfunction

   // Writes all three registers and then the spare index with junk, one write
   // per edge; the enable is lowered only once, after the last one.
   task automatic apply_settings(input logic [CSR_DATA_W-1:0] count_data,
                                 input logic [CSR_DATA_W-1:0] delay_data,
                                 input logic [CSR_DATA_W-1:0] gain_data);
      logic [CSR_INDEX_W-1:0] index_list [4];
      logic [CSR_DATA_W-1:0]  data_list [4];
      index_list = '{CSR_STAGE_COUNT, CSR_STAGE_DELAYS, CSR_STAGE_GAINS, CSR_SPARE_INDEX};
      data_list  = '{count_data, delay_data, gain_data, wide_random()};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= index_list[i];
         csr_wr_data <= data_list[i];
         @(posedge clock);
         diffuser.write_reg(index_list[i], data_list[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   // Offers one sample beat, after a random number of idle cycles. Valid stays
   // high after acceptance so that back-to-back beats need no second drive in
   // the same step; the next call lowers it when it idles, and a drain always does.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= sample;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      diffuser.note_sample(sample);
   endtask

   // Stops offering and waits until every predicted result has come back;
   // the block is then idle and its registers may be written.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (diffuser.outstanding() != 0)
         @(posedge clock);
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct <= 0;
         end
         IDLE_SENDER: begin
            send_idle_pct  = 49;
            recv_stall_pct <= 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct <= 49;
         end
         default: begin
            send_idle_pct  = 23;
            recv_stall_pct <= 23;
         end
      endcase
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] count_data;
      logic [CSR_DATA_W-1:0] delay_data;
      logic [CSR_DATA_W-1:0] gain_data;
      idle_mode_type         mode;

      diffuser = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part, without idling. With no section active every sample,
      // the full-scale ones included, must come straight through. The block
      // is still clearing its histories here; register writes are taken
      // regardless and the first beat simply waits for the clear to finish.
      set_idling(IDLE_NONE);
      apply_settings(CSR_DATA_W'({wide_random() >> COUNT_REG_W, 3'd0}), '0, '0);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'shFFFF);
      send_sample(16'sh0001);

      // All four sections with the shortest delays, section 0 given zero so
      // that it acts as a delay of one, and gains at and beyond both clamp
      // limits. Alternating full-scale samples drive the sums into saturation.
      wait_drained();
      apply_settings(CSR_DATA_W'(3'd4),
                     CSR_DATA_W'({12'd3, 12'd2, 12'd1, 12'd0}),
                     {GAIN_W'(-GAIN_LIMIT), GAIN_W'(GAIN_LIMIT), 16'h8000, 16'h7FFF});
      for (int i = 0; i < 8; i++)
         send_sample(i[0] ? 16'sh8000 : 16'sh7FFF);
      send_sample(16'sh0000);
      send_sample(16'sh0000);

      // A section count above the number of sections must act as four; the
      // longest delay reads only history that the clear has zeroed.
      wait_drained();
      apply_settings(CSR_DATA_W'({wide_random() >> COUNT_REG_W, 3'd7}),
                     {16'hFFFF, {PACKED_SECTIONS{12'hFFF}}},
                     {16'h0001, 16'hFFFF, 16'h0000, GAIN_W'(GAIN_LIMIT + 1)});
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh4000);
      send_sample(16'shC000);
      send_sample(16'sh5555);
      send_sample(16'shAAAA);

      // Random part: each phase picks an idle pattern and a register setting.
      // The first two phases pin the extremes; the rest mostly use short delays
      // and one to four sections, sometimes any count up to seven, so that inactive
      // sections keep stale history that later phases read back.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         mode = idle_mode_type'(p % 4);
         set_idling(mode);
         case (p)
            0: begin
               count_data = CSR_DATA_W'(3'd4);
               delay_data = '0;
               gain_data  = {PACKED_SECTIONS{16'h7FFF}};
            end
            1: begin
               count_data = CSR_DATA_W'({wide_random() >> COUNT_REG_W, 3'd1});
               delay_data = '1;
               gain_data  = {PACKED_SECTIONS{16'h8000}};
            end
            default: begin
               count_data = wide_random();
               count_data[COUNT_REG_W-1:0] = COUNT_REG_W'(($urandom_range(3) == 0) ?
                                             $urandom_range(7) : $urandom_range(1, 4));
               delay_data = pick_delays();
               gain_data  = pick_gains();
            end
         endcase
         apply_settings(count_data, delay_data, gain_data);

         for (int i = 0; i < PHASE_BEATS; i++) begin
            // A long receiver hold-off while samples keep being offered, so
            // that the output register and the input both back up.
            if ((p == 2 || p == 7) && i == 30)
               hold_requests <= hold_requests + 1;
            // A sender pause until everything in flight has come back.
            if ((p == 5 || p == 10) && i == 45)
               wait_drained();
            send_sample(pick_sample());
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (diffuser.error_count == 0 && diffuser.outstanding() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
